[rtl/chlp_pkg.sv]
// shared types, codes and constant tables for the core hot-plug load policy
// no dependencies; imported by every module under rtl
package chlp_pkg;

  // cluster and policy sizing
  localparam int unsigned THREAD_CAP     = 200;
  localparam int unsigned MAX_CORES      = 4;
  localparam int unsigned LOAD_W         = 20;
  localparam int unsigned LOAD_FRAC_BITS = 11;
  localparam int unsigned IDLE_THR_W     = 16;
  localparam int unsigned MASK_W         = 4;
  localparam int unsigned DEMAND_W       = 3;
  localparam int unsigned HOLD_W         = 4;
  localparam int unsigned SHIFT_W        = 2;
  localparam int unsigned NUM_PROFILES   = 6;
  localparam int unsigned NUM_STEPS      = 3;
  localparam int unsigned PROF_W         = 3;
  localparam int unsigned THR_W          = 6;
  localparam int unsigned HYST           = 8;

  // profile codes
  localparam logic [PROF_W-1:0] PROFILE_ECO_FIRST = 3'd3;
  localparam logic [PROF_W-1:0] PROFILE_DISABLE   = 3'd5;

  // command codes
  localparam logic [1:0] CMD_TICK    = 2'd0;
  localparam logic [1:0] CMD_SUSPEND = 2'd1;
  localparam logic [1:0] CMD_RESUME  = 2'd2;

  // register indexes on the configuration port
  localparam logic [1:0] REG_ENABLE        = 2'd0;
  localparam logic [1:0] REG_PROFILE       = 2'd1;
  localparam logic [1:0] REG_IDLE_THRESH   = 2'd2;
  localparam logic [1:0] REG_POSSIBLE      = 2'd3;

  localparam logic [IDLE_THR_W-1:0] IDLE_THR_RESET = 16'd500;
  localparam logic [2:0]            POSSIBLE_RESET = 3'd4;

  // persistence loads, in sample periods
  localparam int unsigned SAMPLE_MS = 268;
  localparam logic [HOLD_W-1:0] HOLD_DUAL = HOLD_W'(2500 / SAMPLE_MS);
  localparam logic [HOLD_W-1:0] HOLD_TRI  = HOLD_W'(1700 / SAMPLE_MS);
  localparam logic [HOLD_W-1:0] HOLD_QUAD = HOLD_W'(1000 / SAMPLE_MS);
  localparam logic [HOLD_W-1:0] HOLD_BUSY = HOLD_W'(3500 / SAMPLE_MS);

  localparam int unsigned THR_DIV = 100000;

  // per-profile step thresholds, whole runnable tasks before hysteresis
  localparam logic [THR_W-1:0] STEP_THR [NUM_PROFILES][NUM_STEPS] = '{
    '{THR_W'(THREAD_CAP * 625 * 4 / THR_DIV), THR_W'(THREAD_CAP * 875 * 4 / THR_DIV),
      THR_W'(THREAD_CAP * 1125 * 4 / THR_DIV)},
    '{THR_W'(THREAD_CAP * 380 * 4 / THR_DIV), THR_W'(THREAD_CAP * 625 * 4 / THR_DIV),
      THR_W'(THREAD_CAP * 875 * 4 / THR_DIV)},
    '{THR_W'(THREAD_CAP * 875 * 4 / THR_DIV), THR_W'(THREAD_CAP * 1625 * 4 / THR_DIV),
      THR_W'(THREAD_CAP * 2125 * 4 / THR_DIV)},
    '{THR_W'(THREAD_CAP * 380 * 4 / THR_DIV), THR_W'(0), THR_W'(0)},
    '{THR_W'(THREAD_CAP * 750 * 4 / THR_DIV), THR_W'(0), THR_W'(0)},
    '{THR_W'(0), THR_W'(0), THR_W'(0)}
  };

  // input word
  typedef struct packed {
    logic [1:0]        command;
    logic [LOAD_W-1:0] system_load;
    logic [MASK_W-1:0] online_mask;
    logic [LOAD_W-1:0] core1_load;
    logic [LOAD_W-1:0] core2_load;
    logic [LOAD_W-1:0] core3_load;
  } sample_t;

  // result word
  typedef struct packed {
    logic [MASK_W-1:0]   bring_up_mask;
    logic [MASK_W-1:0]   take_down_mask;
    logic [DEMAND_W-1:0] core_demand;
    logic [HOLD_W-1:0]   hold_remaining;
  } decision_t;

  // control shared by the threshold lanes
  typedef struct packed {
    logic [DEMAND_W-1:0] last_demand;
    logic [SHIFT_W-1:0]  shift;
  } eval_ctrl_t;

endpackage

[rtl/chlp_step_lane.sv]
// one threshold step lane: tests the system load against one demand step
// depends on chlp_pkg
module chlp_step_lane (
  input  logic [chlp_pkg::LOAD_W-1:0]   load,
  input  logic [chlp_pkg::THR_W-1:0]    thr,
  input  logic [chlp_pkg::DEMAND_W-1:0] step_num,
  input  chlp_pkg::eval_ctrl_t          ctrl,
  output logic                          hit
);
  import chlp_pkg::*;

  logic [THR_W:0]  thr_hyst;
  logic [LOAD_W-1:0] limit;

  // hysteresis when the last demand sits at or below this step
  assign thr_hyst = {1'b0, thr} + ((ctrl.last_demand <= step_num) ? (THR_W+1)'(HYST)
                                                                   : '0);

  // scale to 11 fraction bits, less the profile shift
  assign limit = LOAD_W'({thr_hyst, {LOAD_FRAC_BITS{1'b0}}}) >> ctrl.shift;

  assign hit = (load <= limit);

endmodule

[rtl/chlp_core_lane.sv]
// one per-core idle lane: flags an online core whose load is below the idle threshold
// depends on chlp_pkg
module chlp_core_lane (
  input  logic                            online,
  input  logic [chlp_pkg::LOAD_W-1:0]     load,
  input  logic [chlp_pkg::IDLE_THR_W-1:0] idle_thr,
  output logic                            idle
);
  import chlp_pkg::*;

  assign idle = online && (load < LOAD_W'(idle_thr));

endmodule

[rtl/core_hotplug_load_policy.sv]
// top level of the core hot-plug load policy: config registers, lanes, merge, output register
// depends on chlp_pkg, chlp_step_lane, chlp_core_lane

// One sample word is taken every clock cycle unless sample_stall is high; its decision
// word appears on the output register in the next cycle. Threshold steps and per-core
// idle tests run in parallel lanes and are merged in the same cycle, so the demand and
// persistence state updated by one word is ready for the next one. While the output
// register holds an untaken word, sample_stall follows decision_stall. With enable
// clear, words are accepted and give no decision. There is no clearing pass after reset.
module core_hotplug_load_policy (
  input  logic                clk,
  input  logic                rst,
  // sample channel
  input  logic                sample_valid,
  output logic                sample_stall,
  input  chlp_pkg::sample_t   sample,
  // decision channel
  output logic                decision_valid,
  input  logic                decision_stall,
  output chlp_pkg::decision_t decision,
  // configuration port
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [3:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  import chlp_pkg::*;

  logic                  enable;
  logic [PROF_W-1:0]     profile;
  logic [IDLE_THR_W-1:0] core_idle_threshold;
  logic [2:0]            possible_cores;

  logic [DEMAND_W-1:0]   last_demand, last_demand_next;
  logic [HOLD_W-1:0]     hold_count, hold_count_next;
  logic                  asleep, asleep_next;

  logic                  accept;
  logic                  cfg_write;
  logic [1:0]            cfg_index;

  logic [PROF_W-1:0]     prof;
  logic [2:0]            cores;
  logic                  eco;
  logic [DEMAND_W-1:0]   table_size;
  eval_ctrl_t            ctrl;
  logic [MASK_W-1:0]     present_mask;
  logic [MASK_W-1:0]     online;
  logic [2:0]            ncpu;

  logic [NUM_STEPS-1:0]  step_hit;
  logic [LOAD_W-1:0]     core_load [1:MASK_W-1];
  logic [MASK_W-1:0]     idle_mask;

  logic [DEMAND_W-1:0]   demand;
  logic [HOLD_W-1:0]     hold_dec;
  decision_t             result;

  // configuration port
  assign pready    = 1'b1;
  assign cfg_index = paddr[3:2];
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      enable              <= 1'b0;
      profile             <= '0;
      core_idle_threshold <= IDLE_THR_RESET;
      possible_cores      <= POSSIBLE_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_ENABLE:      enable              <= pwdata[0];
        REG_PROFILE:     profile             <= pwdata[PROF_W-1:0];
        REG_IDLE_THRESH: core_idle_threshold <= pwdata[IDLE_THR_W-1:0];
        REG_POSSIBLE:    possible_cores      <= pwdata[2:0];
        default:         ;
      endcase
    end
  end

  always_comb begin
    case (cfg_index)
      REG_ENABLE:      prdata = {31'b0, enable};
      REG_PROFILE:     prdata = {{(32-PROF_W){1'b0}}, profile};
      REG_IDLE_THRESH: prdata = {{(32-IDLE_THR_W){1'b0}}, core_idle_threshold};
      REG_POSSIBLE:    prdata = {29'b0, possible_cores};
      default:         prdata = '0;
    endcase
  end

  // clamped profile and core count, table length and load shift
  always_comb begin
    prof = (profile > PROFILE_DISABLE) ? PROFILE_DISABLE : profile;
    if (possible_cores == 3'd0) begin
      cores = 3'd1;
    end else if (possible_cores > 3'(MAX_CORES)) begin
      cores = 3'(MAX_CORES);
    end else begin
      cores = possible_cores;
    end
    eco        = (prof >= PROFILE_ECO_FIRST);
    table_size = (cores > 3'd2 && !eco) ? 3'd4 : 3'd2;
    ctrl.last_demand = last_demand;
    ctrl.shift       = eco ? 2'd1 : SHIFT_W'(cores - 3'd1);
    present_mask     = MASK_W'((5'd1 << cores) - 5'd1);
    online           = sample.online_mask & present_mask;
    ncpu             = 3'($countones(online));
  end

  // threshold step lanes
  for (genvar n = 0; n < NUM_STEPS; n++) begin : g_step
    chlp_step_lane u_step (
      .load     (sample.system_load),
      .thr      (STEP_THR[prof][n]),
      .step_num (DEMAND_W'(n + 1)),
      .ctrl     (ctrl),
      .hit      (step_hit[n])
    );
  end

  // per-core idle lanes
  assign core_load[1] = sample.core1_load;
  assign core_load[2] = sample.core2_load;
  assign core_load[3] = sample.core3_load;
  assign idle_mask[0] = 1'b0;

  for (genvar c = 1; c < MASK_W; c++) begin : g_core
    chlp_core_lane u_core (
      .online   (online[c]),
      .load     (core_load[c]),
      .idle_thr (core_idle_threshold),
      .idle     (idle_mask[c])
    );
  end

  // merge: first step that holds the load gives the demand
  always_comb begin
    demand = table_size;
    for (int n = NUM_STEPS - 1; n >= 0; n--) begin
      if ((DEMAND_W'(n + 1) < table_size) && step_hit[n]) begin
        demand = DEMAND_W'(n + 1);
      end
    end
  end

  assign hold_dec = (hold_count != '0) ? hold_count - HOLD_W'(1) : '0;

  // decision and next state
  always_comb begin
    last_demand_next      = last_demand;
    hold_count_next       = hold_count;
    asleep_next           = asleep;
    result.bring_up_mask  = '0;
    result.take_down_mask = '0;
    result.core_demand    = '0;
    if (sample.command == CMD_TICK && !asleep) begin
      last_demand_next   = demand;
      result.core_demand = demand;
      hold_count_next    = hold_dec;
      case (demand)
        3'd1: begin
          if (hold_dec == '0) begin
            result.take_down_mask = idle_mask;
          end
        end
        3'd2: begin
          if (hold_dec == '0) begin
            hold_count_next = HOLD_DUAL;
          end
          if (ncpu < 3'd2) begin
            result.bring_up_mask = 4'b0010;
          end else begin
            result.take_down_mask = idle_mask & 4'b1100;
          end
        end
        3'd3: begin
          if (hold_dec == '0) begin
            hold_count_next = HOLD_TRI;
          end
          if (ncpu < 3'd3) begin
            result.bring_up_mask = 4'b0010;
          end else begin
            result.take_down_mask = idle_mask & 4'b1000;
          end
        end
        default: begin
          if (hold_dec == '0) begin
            hold_count_next = HOLD_QUAD;
          end
          if (ncpu < 3'd4) begin
            result.bring_up_mask = 4'b0010;
          end
        end
      endcase
    end else if (sample.command == CMD_SUSPEND) begin
      asleep_next           = 1'b1;
      result.take_down_mask = online & 4'b1110;
    end else if (sample.command == CMD_RESUME) begin
      hold_count_next      = HOLD_BUSY;
      asleep_next          = 1'b0;
      result.bring_up_mask = 4'b0010;
    end
    result.hold_remaining = hold_count_next;
  end

  // handshake: a new word enters whenever the output register is free or draining
  assign sample_stall = decision_valid && decision_stall;
  assign accept       = sample_valid && !sample_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      last_demand    <= '0;
      hold_count     <= '0;
      asleep         <= 1'b0;
      decision_valid <= 1'b0;
    end else begin
      if (accept && enable) begin
        last_demand    <= last_demand_next;
        hold_count     <= hold_count_next;
        asleep         <= asleep_next;
        decision_valid <= 1'b1;
      end else if (!decision_stall) begin
        decision_valid <= 1'b0;
      end
    end
  end

  // output word register
  always_ff @(posedge clk) begin
    if (accept && enable) begin
      decision <= result;
    end
  end

endmodule

[bench/core_hotplug_load_policy_test.sv]
// self-checking bench for core_hotplug_load_policy: drives sample words, predicts
// each decision word and compares it; configures the policy over the register port
// depends on chlp_pkg and the core_hotplug_load_policy rtl
module core_hotplug_load_policy_test;
  timeunit 1ns;
  timeprecision 1ps;

  import chlp_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned DRAIN_CYCLES = 6;
  localparam int unsigned FRAC_BITS    = 11;
  localparam int unsigned CORE_LIMIT   = 4;
  localparam int unsigned TASK_CAP     = 200;
  localparam logic [1:0]  CMD_UNKNOWN  = 2'd3;

  // persistence loads in sample periods
  localparam int unsigned HOLD_PAIR   = 2500 / 268;
  localparam int unsigned HOLD_TRIPLE = 1700 / 268;
  localparam int unsigned HOLD_ALL    = 1000 / 268;
  localparam int unsigned HOLD_WAKE   = 3500 / 268;

  // load multipliers of the three demand steps, per profile
  localparam int unsigned STEP_MULT [6][3] = '{
    '{625, 875, 1125}, '{380, 625, 875}, '{875, 1625, 2125},
    '{380, 0, 0}, '{750, 0, 0}, '{0, 0, 0}
  };
  // whole-task step thresholds that occur, used to aim loads at the edges
  localparam int unsigned EDGE_STEPS [8] = '{0, 3, 5, 6, 7, 9, 13, 17};

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        sample_valid = 1'b0;
  logic        sample_stall;
  sample_t     sample = '0;
  logic        decision_valid;
  logic        decision_stall = 1'b0;
  decision_t   decision;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  // policy registers as the bench believes them to be
  logic        cfg_enable = 1'b0;
  logic [2:0]  cfg_profile = 3'd0;
  logic [15:0] cfg_idle_thr = 16'd500;
  logic [2:0]  cfg_possible = 3'd4;

  // policy state mirrored by the predictor
  int unsigned last_want = 0;
  int unsigned hold_left = 0;
  bit          suspended = 1'b0;

  sample_t     samples_to_send[$];
  decision_t   decisions_due[$];
  decision_t   due_word;
  decision_t   planned;
  int          send_idle_pct = 34;
  int          recv_idle_pct = 75;
  int unsigned errors = 0;
  int unsigned cycles = 0;

  core_hotplug_load_policy i_dut (
    .clk(clk), .rst(rst),
    .sample_valid(sample_valid), .sample_stall(sample_stall), .sample(sample),
    .decision_valid(decision_valid), .decision_stall(decision_stall), .decision(decision),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready)
  );

  always #10 clk = ~clk;

  // cores above min_core that are online and lightly loaded
  function automatic int unsigned idle_cores(input int unsigned online,
                                             input int unsigned min_core,
                                             input sample_t s);
    int unsigned down;
    int unsigned load;
    down = 0;
    for (int c = 1; c < 4; c++) begin
      load = (c == 1) ? s.core1_load : (c == 2) ? s.core2_load : s.core3_load;
      if (online[c] && c > min_core && load < cfg_idle_thr) down |= 1 << c;
    end
    return down;
  endfunction

  // hot-plug decision for one sample word; returns 0 while the policy is off
  function automatic bit plan_cores(input sample_t s, output decision_t d);
    int unsigned present, online, ncpu, prof, size, shift, thr, want, up, down;
    bit          stop;
    d = '0;
    if (!cfg_enable) return 1'b0;
    present = (cfg_possible < 1) ? 1 : (cfg_possible > CORE_LIMIT) ? CORE_LIMIT : cfg_possible;
    online  = s.online_mask & ((1 << present) - 1);
    up = 0;
    down = 0;
    want = 0;
    if (s.command == CMD_TICK && !suspended) begin
      ncpu  = $countones(online[3:0]);
      prof  = (cfg_profile > PROFILE_DISABLE) ? PROFILE_DISABLE : cfg_profile;
      size  = (present > 2 && prof < PROFILE_ECO_FIRST) ? 4 : 2;
      shift = (prof >= PROFILE_ECO_FIRST) ? 1 : present - 1;
      // walk the steps until the load fits under one
      want = 1;
      stop = 1'b0;
      while (want < size && !stop) begin
        thr = TASK_CAP * STEP_MULT[prof][want - 1] * 4 / 100000;
        if (last_want <= want) thr += 8;
        if (s.system_load <= (thr << (FRAC_BITS - shift))) stop = 1'b1;
        else want++;
      end
      last_want = want;
      if (hold_left > 0) hold_left--;
      case (want)
        1: begin
          if (hold_left == 0) down = idle_cores(online, 0, s);
        end
        2: begin
          if (hold_left == 0) hold_left = HOLD_PAIR;
          if (ncpu < 2) up = 2;
          else down = idle_cores(online, 1, s);
        end
        3: begin
          if (hold_left == 0) hold_left = HOLD_TRIPLE;
          if (ncpu < 3) up = 2;
          else down = idle_cores(online, 2, s);
        end
        default: begin
          if (hold_left == 0) hold_left = HOLD_ALL;
          if (ncpu < 4) up = 2;
        end
      endcase
    end else if (s.command == CMD_SUSPEND) begin
      suspended = 1'b1;
      down = online & 4'hE;
    end else if (s.command == CMD_RESUME) begin
      hold_left = HOLD_WAKE;
      suspended = 1'b0;
      up = 2;
    end
    hold_left &= 4'hF;
    d.bring_up_mask  = up[3:0];
    d.take_down_mask = down[3:0];
    d.core_demand    = want[2:0];
    d.hold_remaining = hold_left[3:0];
    return 1'b1;
  endfunction

  function automatic sample_t make_sample(input logic [1:0] cmd, input int unsigned load,
                                          input logic [3:0] mask, input int unsigned l1,
                                          input int unsigned l2, input int unsigned l3);
    sample_t s;
    s.command     = cmd;
    s.system_load = load[19:0];
    s.online_mask = mask;
    s.core1_load  = l1[19:0];
    s.core2_load  = l2[19:0];
    s.core3_load  = l3[19:0];
    return s;
  endfunction

  // per-core load, mostly around the idle threshold
  function automatic int unsigned pick_core_load();
    if ($urandom_range(9) < 7) return $urandom_range(2 * cfg_idle_thr + 1);
    return $urandom_range(20'hFFFFF);
  endfunction

  // mostly ticks with loads aimed at the step edges, some suspend and resume
  function automatic sample_t random_sample();
    int unsigned r, base, load;
    logic [1:0]  cmd;
    r = $urandom_range(199);
    cmd = (r < 3) ? CMD_SUSPEND : (r < 12) ? CMD_RESUME : (r < 196) ? CMD_TICK : CMD_UNKNOWN;
    r = $urandom_range(9);
    if (r < 6) begin
      base = (EDGE_STEPS[$urandom_range(7)] + ($urandom_range(1) ? 8 : 0))
             << (FRAC_BITS - $urandom_range(3));
      load = base + $urandom_range(4);
      load = (load >= 2) ? load - 2 : 0;
    end else if (r < 9) begin
      load = $urandom_range(16'hFFFF);
    end else begin
      load = $urandom_range(20'hFFFFF);
    end
    return make_sample(cmd, load, 4'($urandom_range(15)), pick_core_load(),
                       pick_core_load(), pick_core_load());
  endfunction

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_ENABLE:      cfg_enable = value[0];
      REG_PROFILE:     cfg_profile = value[2:0];
      REG_IDLE_THRESH: cfg_idle_thr = value[15:0];
      REG_POSSIBLE:    cfg_possible = value[2:0];
      default: ;
    endcase
  endtask

  task automatic set_policy(input logic en, input logic [2:0] prof, input logic [15:0] thr,
                            input logic [2:0] possible);
    write_reg(REG_ENABLE, {31'd0, en});
    write_reg(REG_PROFILE, {29'd0, prof});
    write_reg(REG_IDLE_THRESH, {16'd0, thr});
    write_reg(REG_POSSIBLE, {29'd0, possible});
  endtask

  // hold off until every word is sent and answered, then let the pipe settle
  task automatic wait_quiet();
    while (samples_to_send.size() != 0 || sample_valid || decisions_due.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic check_field(input string what, input int unsigned want, input int unsigned got);
    if (want != got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, what, want, got);
    end
  endtask

  // sample driver
  always @(posedge clk) begin
    if (rst) begin
      sample_valid <= 1'b0;
    end else if (!sample_valid || !sample_stall) begin
      if (samples_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        sample       <= samples_to_send.pop_front();
        sample_valid <= 1'b1;
      end else begin
        sample_valid <= 1'b0;
      end
    end
  end

  // predict the decision for every accepted word
  always @(posedge clk) begin
    if (!rst && sample_valid && !sample_stall) begin
      if (plan_cores(sample, planned)) decisions_due.push_back(planned);
    end
  end

  // decision receiver stall
  always @(posedge clk) begin
    decision_stall <= (recv_idle_pct > 0) && ($urandom_range(99) < recv_idle_pct);
  end

  // decision monitor
  always @(posedge clk) begin
    if (!rst && decision_valid && !decision_stall) begin
      if (decisions_due.size() == 0) begin
        errors++;
        $display("%0t: unexpected decision word, expected none actual %0h", $time, decision);
      end else begin
        due_word = decisions_due.pop_front();
        check_field("bring_up_mask", due_word.bring_up_mask, decision.bring_up_mask);
        check_field("take_down_mask", due_word.take_down_mask, decision.take_down_mask);
        check_field("core_demand", due_word.core_demand, decision.core_demand);
        check_field("hold_remaining", due_word.hold_remaining, decision.hold_remaining);
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL core_hotplug_load_policy");
      $finish;
    end
  end

  // stimulus and end of run
  initial begin
    int          n;
    logic        en;
    logic [2:0]  prof, possible;
    logic [15:0] thr;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // words while the policy is still off after reset
    samples_to_send.push_back(make_sample(CMD_TICK, 20'hFFFFF, 4'h1, 0, 0, 0));
    samples_to_send.push_back(make_sample(CMD_RESUME, 0, 4'hF, 0, 0, 0));
    wait_quiet();

    // balance profile, four cores: steps, hysteresis, idle edges, suspend and resume
    set_policy(1'b1, 3'd0, 16'd500, 3'd4);
    samples_to_send.push_back(make_sample(CMD_TICK, 0, 4'hF, 0, 0, 0));
    samples_to_send.push_back(make_sample(CMD_TICK, 20'hFFFFF, 4'h1, 20'hFFFFF, 20'hFFFFF,
                                          20'hFFFFF));
    samples_to_send.push_back(make_sample(CMD_TICK, 20'hFFFFF, 4'hF, 0, 0, 0));
    samples_to_send.push_back(make_sample(CMD_TICK, 1280, 4'hF, 0, 20'hFFFFF, 0));
    samples_to_send.push_back(make_sample(CMD_TICK, 1281, 4'hF, 0, 0, 0));
    samples_to_send.push_back(make_sample(CMD_TICK, 3328, 4'hF, 0, 0, 0));
    samples_to_send.push_back(make_sample(CMD_TICK, 0, 4'hF, 499, 500, 20'hFFFFF));
    samples_to_send.push_back(make_sample(CMD_SUSPEND, 0, 4'hF, 0, 0, 0));
    samples_to_send.push_back(make_sample(CMD_TICK, 20'hFFFFF, 4'h1, 0, 0, 0));
    samples_to_send.push_back(make_sample(CMD_SUSPEND, 0, 4'h0, 0, 0, 0));
    samples_to_send.push_back(make_sample(CMD_RESUME, 0, 4'h1, 0, 0, 0));
    samples_to_send.push_back(make_sample(CMD_UNKNOWN, 20'hFFFFF, 4'hF, 0, 0, 0));
    samples_to_send.push_back(make_sample(CMD_TICK, 20'h55555, 4'hA, 20'hAAAAA, 20'h55555,
                                          20'hAAAAA));
    samples_to_send.push_back(make_sample(CMD_TICK, 20'hAAAAA, 4'h5, 20'h55555, 20'hAAAAA,
                                          20'h55555));
    wait_quiet();

    // eco profile on two cores: upper online bits must be ignored
    set_policy(1'b1, PROFILE_ECO_FIRST, 16'hFFFF, 3'd2);
    samples_to_send.push_back(make_sample(CMD_TICK, 0, 4'hF, 0, 0, 0));
    samples_to_send.push_back(make_sample(CMD_TICK, 20'hFFFFF, 4'hD, 0, 0, 0));
    samples_to_send.push_back(make_sample(CMD_TICK, 11264, 4'hF, 0, 0, 0));
    samples_to_send.push_back(make_sample(CMD_TICK, 11265, 4'h3, 0, 0, 0));
    wait_quiet();

    // random blocks, each under its own policy setting
    for (int k = 0; k < 26; k++) begin
      if (k < 9) begin
        send_idle_pct = 34;
        recv_idle_pct = 75;
      end else if (k < 18) begin
        send_idle_pct = 75;
        recv_idle_pct = 34;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      wait_quiet();
      case (k)
        0: begin en = 1'b1; prof = 3'd7; thr = 16'd0;     possible = 3'd0; end
        1: begin en = 1'b1; prof = 3'd6; thr = 16'hFFFF;  possible = 3'd7; end
        2: begin en = 1'b0; prof = 3'd5; thr = 16'd1000;  possible = 3'd1; end
        3: begin en = 1'b1; prof = 3'd5; thr = 16'd500;   possible = 3'd4; end
        default: begin
          en   = ($urandom_range(11) != 0);
          prof = 3'($urandom_range(7));
          case ($urandom_range(3))
            0: thr = 16'd0;
            1: thr = 16'hFFFF;
            2: thr = 16'($urandom_range(2000));
            default: thr = 16'($urandom_range(16'hFFFF));
          endcase
          possible = ($urandom_range(9) < 8) ? 3'($urandom_range(4, 1))
                                             : 3'($urandom_range(7));
        end
      endcase
      set_policy(en, prof, thr, possible);
      n = en ? 50 : 15;
      repeat (n) samples_to_send.push_back(random_sample());
    end

    wait_quiet();
    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("PASS core_hotplug_load_policy");
    end else begin
      $display("FAIL core_hotplug_load_policy");
    end
    $finish;
  end

endmodule
